[rtl/seven_segment_number_display_scanner_macros.svh]
// Assertion macros shared by the display scanner RTL.
`ifndef SEVEN_SEGMENT_NUMBER_DISPLAY_SCANNER_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_DISPLAY_SCANNER_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define SSNDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define SSNDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ssnds_pkg.sv]
// Shared types, constants and helpers of the seven-segment display scanner.
package ssnds_pkg;

  localparam int VALUE_W = 20;
  localparam int SEG_W = 8;
  localparam int SEL_W = 3;
  localparam int REQ_W = 2;
  localparam int DIGITS = 6;
  localparam int POSITIONS_DEF = 7;

  localparam logic [SEG_W-1:0] BLANK_BYTE = 8'hFF;
  localparam logic [SEG_W-1:0] DASH_BYTE = 8'hBF;
  localparam logic [SEG_W-1:0] POINT_MASK = 8'h7F;

  // Values at or above this keep only their six low decimal digits
  localparam logic [VALUE_W-1:0] VALUE_WRAP = 20'd1000000;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_SHOW = 2'd0,
    REQ_SET  = 2'd1,
    REQ_SCAN = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // Active-low hex glyphs, bit 7 is the decimal point
  localparam logic [SEG_W-1:0] GLYPHS [16] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
  };

  // Reciprocals for exact division of a 20-bit value by powers of ten:
  // m = floor(2^(20+l) / d) + 1 with l = ceil(log2 d)
  localparam int RECIP_W = VALUE_W + 1;
  localparam int SHIFT_1E1 = 24;
  localparam int SHIFT_1E2 = 27;
  localparam int SHIFT_1E3 = 30;
  localparam int SHIFT_1E4 = 34;
  localparam int SHIFT_1E5 = 37;
  localparam logic [RECIP_W-1:0] RECIP_1E1 =
    RECIP_W'((64'd1 << SHIFT_1E1) / 64'd10 + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_1E2 =
    RECIP_W'((64'd1 << SHIFT_1E2) / 64'd100 + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_1E3 =
    RECIP_W'((64'd1 << SHIFT_1E3) / 64'd1000 + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_1E4 =
    RECIP_W'((64'd1 << SHIFT_1E4) / 64'd10000 + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP_1E5 =
    RECIP_W'((64'd1 << SHIFT_1E5) / 64'd100000 + 64'd1);

  // Quotient by reciprocal multiply and shift
  function automatic logic [VALUE_W-1:0] recip_div(
    input logic [VALUE_W-1:0] v,
    input logic [RECIP_W-1:0] m,
    input int unsigned s
  );
    logic [VALUE_W+RECIP_W-1:0] prod;
    prod = (VALUE_W+RECIP_W)'(v) * (VALUE_W+RECIP_W)'(m);
    return VALUE_W'(prod >> s);
  endfunction

endpackage

[rtl/seven_segment_number_display_scanner.sv]
// Multiplexed seven-segment display scanner: input stage, formatter, buffer, result register.
// A scan tick item is held in the input stage, then its result is registered in the result register.
// Throughput: one item per cycle; the input stage waits only while a scan tick
// finds the result register full and stalled.
// Reset (rst, synchronous): buffer bytes all blank (0xFF), scan position 0,
// no item held and no result pending.
`include "seven_segment_number_display_scanner_macros.svh"

module seven_segment_number_display_scanner #(
  parameter int POSITIONS = ssnds_pkg::POSITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [ssnds_pkg::REQ_W-1:0]   req_type,
  input  logic [ssnds_pkg::VALUE_W-1:0] value,
  input  logic [ssnds_pkg::SEL_W-1:0]   position,
  input  logic                          decimal_point,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [ssnds_pkg::SEG_W-1:0]   segments,
  output logic [ssnds_pkg::SEL_W-1:0]   select
);
  import ssnds_pkg::*;

  localparam int POS_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

  // Input stage
  logic                 s1_valid;
  req_t                 s1_req;
  logic [VALUE_W-1:0]   s1_value;
  logic [SEL_W-1:0]     s1_position;
  logic                 s1_dp;
  logic                 s1_go;

  // Buffer and scan state
  logic [SEG_W-1:0]     display_buffer [POSITIONS];
  logic [POS_W-1:0]     scan_pos;
  logic [POS_W-1:0]     scan_pos_next;

  logic [DIGITS-1:0][SEG_W-1:0] show_bytes;
  logic [SEG_W-1:0]     set_byte;
  logic                 do_show, do_set, do_scan;

  // Stage advances unless a scan tick meets a full, stalled result register
  assign s1_go = !(s1_req == REQ_SCAN) || !result_valid || !result_stall;
  assign item_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_req      <= req_t'(req_type);
      s1_value    <= value;
      s1_position <= position;
      s1_dp       <= decimal_point;
    end
  end

  // Request decode
  always_comb begin
    do_show = 1'b0;
    do_set  = 1'b0;
    do_scan = 1'b0;
    unique case (s1_req)
      REQ_SHOW: do_show = s1_valid;
      REQ_SET:  do_set  = s1_valid;
      REQ_SCAN: do_scan = s1_valid && s1_go;
      default:  ;
    endcase
  end

  ssnds_format u_format (
    .value (s1_value),
    .bytes (show_bytes)
  );

  assign set_byte = s1_dp ? (GLYPHS[s1_value[3:0]] & POINT_MASK) : GLYPHS[s1_value[3:0]];

  // Buffer entries; digit positions take formatted bytes, any position takes set-digit
  for (genvar i = 0; i < POSITIONS; i++) begin : g_buf
    always_ff @(posedge clk) begin
      if (rst) begin
        display_buffer[i] <= BLANK_BYTE;
      end else if (do_show && (i < DIGITS)) begin
        display_buffer[i] <= show_bytes[(i < DIGITS) ? i : 0];
      end else if (do_set && (s1_position == SEL_W'(i))) begin
        display_buffer[i] <= set_byte;
      end
    end
  end

  // Scan position wraps after the last position
  assign scan_pos_next = (scan_pos == POS_W'(POSITIONS - 1)) ? '0 : scan_pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= '0;
    end else if (do_scan) begin
      scan_pos <= scan_pos_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (do_scan) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_scan) begin
      segments <= display_buffer[scan_pos];
      select   <= SEL_W'(scan_pos);
    end
  end

  // Checks
  `SSNDS_ASSERT_NOW(a_select_range, result_valid, select < POSITIONS, "select out of range")
  `SSNDS_ASSERT_NEXT(a_scan_result, do_scan, result_valid, "scan tick lost its item")
  `SSNDS_ASSERT_NEXT(a_scan_hold, !do_scan, $stable(scan_pos), "scan position moved")
  `SSNDS_ASSERT_NOW(a_stall_cause, item_stall, s1_valid && result_valid, "spurious stall")

endmodule

[rtl/ssnds_format.sv]
// Number formatter: six decimal digits with leading-zero blanking and dash.
module ssnds_format (
  input  logic [ssnds_pkg::VALUE_W-1:0]                      value,
  output logic [ssnds_pkg::DIGITS-1:0][ssnds_pkg::SEG_W-1:0] bytes
);
  import ssnds_pkg::*;

  logic [VALUE_W-1:0] low6;
  logic [VALUE_W-1:0] quot [DIGITS];
  logic [3:0]         dig [DIGITS];
  logic               top5, top4, top3;

  // Keep the six low decimal digits
  assign low6 = (value >= VALUE_WRAP) ? value - VALUE_WRAP : value;

  // Quotients by 10^k, all in parallel
  assign quot[0] = low6;
  assign quot[1] = recip_div(low6, RECIP_1E1, SHIFT_1E1);
  assign quot[2] = recip_div(low6, RECIP_1E2, SHIFT_1E2);
  assign quot[3] = recip_div(low6, RECIP_1E3, SHIFT_1E3);
  assign quot[4] = recip_div(low6, RECIP_1E4, SHIFT_1E4);
  assign quot[5] = recip_div(low6, RECIP_1E5, SHIFT_1E5);

  // Digit k = q_k - 10 * q_(k+1); only the low nibble matters
  always_comb begin
    for (int k = 0; k < DIGITS - 1; k++) begin
      dig[k] = 4'(quot[k] - ((quot[k+1] << 3) + (quot[k+1] << 1)));
    end
    dig[DIGITS-1] = 4'(quot[DIGITS-1]);
  end

  // Highest nonzero digit among the upper three
  assign top5 = (dig[5] != 4'd0);
  assign top4 = top5 || (dig[4] != 4'd0);
  assign top3 = top4 || (dig[3] != 4'd0);

  // Blank above the leading digit; dash in position 2 when the upper three are zero
  always_comb begin
    bytes[0] = GLYPHS[dig[0]];
    bytes[1] = GLYPHS[dig[1]];
    bytes[2] = top3 ? GLYPHS[dig[2]] : DASH_BYTE;
    bytes[3] = top3 ? GLYPHS[dig[3]] : BLANK_BYTE;
    bytes[4] = top4 ? GLYPHS[dig[4]] : BLANK_BYTE;
    bytes[5] = top5 ? GLYPHS[dig[5]] : BLANK_BYTE;
  end

endmodule

[sim/ssnds_scan_checker.sv]
`timescale 1ns / 1ps
// Watches both channels of the display scanner, predicts each scan item and compares it.
module ssnds_scan_checker #(
  parameter int POSITIONS = ssnds_pkg::POSITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic [ssnds_pkg::REQ_W-1:0]   req_type,
  input  logic [ssnds_pkg::VALUE_W-1:0] value,
  input  logic [ssnds_pkg::SEL_W-1:0]   position,
  input  logic                          decimal_point,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [ssnds_pkg::SEG_W-1:0]   segments,
  input  logic [ssnds_pkg::SEL_W-1:0]   select,
  output int                            fail_count,
  output int                            pending_scans
);
  import ssnds_pkg::*;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [SEL_W-1:0] sel;
  } scan_out_t;

  // Predicted display contents and scan pointer
  logic [SEG_W-1:0] shown [8];
  logic [SEL_W-1:0] scan_idx;
  scan_out_t        scans_due [$];
  int               errors;

  // Active-low hex glyph, bit 7 is the decimal point
  function automatic logic [SEG_W-1:0] hex_seg(input logic [3:0] nib);
    case (nib)
      4'h0: return 8'hC0;
      4'h1: return 8'hF9;
      4'h2: return 8'hA4;
      4'h3: return 8'hB0;
      4'h4: return 8'h99;
      4'h5: return 8'h92;
      4'h6: return 8'h82;
      4'h7: return 8'hF8;
      4'h8: return 8'h80;
      4'h9: return 8'h90;
      4'hA: return 8'h88;
      4'hB: return 8'h83;
      4'hC: return 8'hC6;
      4'hD: return 8'hA1;
      4'hE: return 8'h86;
      default: return 8'h8E;
    endcase
  endfunction

  // Positions past the configured count are never written
  function automatic void store_byte(input int unsigned p, input logic [SEG_W-1:0] b);
    if (p < POSITIONS) shown[p] = b;
  endfunction

  // Six low decimal digits, leading zeros of the top three blanked
  function automatic void show_value(input logic [VALUE_W-1:0] v);
    int unsigned rest;
    int unsigned dig [6];
    int lead;
    rest = v;
    for (int k = 0; k < DIGITS; k++) begin
      dig[k] = rest % 10;
      rest = rest / 10;
    end
    lead = -1;
    for (int k = 5; k >= 3; k--) begin
      if (lead < 0 && dig[k] != 0) lead = k;
    end
    if (lead < 0) begin
      // small number: dash in position 2, tens digit shown even when zero
      store_byte(5, BLANK_BYTE);
      store_byte(4, BLANK_BYTE);
      store_byte(3, BLANK_BYTE);
      store_byte(2, DASH_BYTE);
      store_byte(1, hex_seg(4'(dig[1])));
      store_byte(0, hex_seg(4'(dig[0])));
    end else begin
      for (int k = 5; k >= 0; k--) begin
        store_byte(k, (k > lead) ? BLANK_BYTE : hex_seg(4'(dig[k])));
      end
    end
  endfunction

  // Compare accepted results first, then fold in the accepted item
  always @(posedge clk) begin
    scan_out_t want;
    logic [SEG_W-1:0] glyph;
    if (rst) begin
      for (int k = 0; k < 8; k++) shown[k] = BLANK_BYTE;
      scan_idx = '0;
      scans_due.delete();
      errors = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (scans_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected scan item, expected none, got segments=%h select=%0d",
                   $time, segments, select);
        end else begin
          want = scans_due.pop_front();
          if (segments !== want.seg) begin
            errors++;
            $display("%0t: segments mismatch, expected %h, got %h", $time, want.seg, segments);
          end
          if (select !== want.sel) begin
            errors++;
            $display("%0t: select mismatch, expected %0d, got %0d", $time, want.sel, select);
          end
        end
      end
      if (item_valid && !item_stall) begin
        case (req_t'(req_type))
          REQ_SHOW: show_value(value);
          REQ_SET: begin
            glyph = hex_seg(value[3:0]);
            if (decimal_point) glyph = glyph & POINT_MASK;
            store_byte(position, glyph);
          end
          REQ_SCAN: begin
            want.seg = shown[scan_idx];
            want.sel = scan_idx;
            scans_due.push_back(want);
            if (int'(scan_idx) + 1 >= POSITIONS) scan_idx = '0;
            else scan_idx = scan_idx + 1'b1;
          end
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending_scans <= scans_due.size();
  end

endmodule

[sim/tb_seven_segment_number_display_scanner.sv]
`timescale 1ns / 1ps
// Testbench top: drives display requests with bursts and receiver stalls, gives the verdict.
module tb_seven_segment_number_display_scanner;
  import ssnds_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 160;
  localparam int DRAIN_CYCLES = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [REQ_W-1:0]   req_type = REQ_NONE;
  logic [VALUE_W-1:0] value = '0;
  logic [SEL_W-1:0]   position = '0;
  logic               decimal_point = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [SEG_W-1:0]   segments;
  logic [SEL_W-1:0]   select;
  int                 fail_count;
  int                 pending_scans;
  int                 quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  seven_segment_number_display_scanner u_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .req_type      (req_type),
    .value         (value),
    .position      (position),
    .decimal_point (decimal_point),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .segments      (segments),
    .select        (select)
  );

  ssnds_scan_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .req_type      (req_type),
    .value         (value),
    .position      (position),
    .decimal_point (decimal_point),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .segments      (segments),
    .select        (select),
    .fail_count    (fail_count),
    .pending_scans (pending_scans)
  );

  // Present one item and hold it until the block takes it
  task automatic offer_item(input req_t kind, input logic [VALUE_W-1:0] v,
                            input logic [SEL_W-1:0] p, input logic dp);
    item_valid <= 1'b1;
    req_type <= kind;
    value <= v;
    position <= p;
    decimal_point <= dp;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Weighted random request; reports whether the block acts on it
  task automatic send_random_item(output bit acts);
    int unsigned pick;
    logic [VALUE_W-1:0] v;
    logic [SEL_W-1:0] p;
    logic dp;
    req_t kind;
    pick = $urandom_range(0, 99);
    v = VALUE_W'($urandom);
    p = SEL_W'($urandom);
    dp = 1'($urandom);
    if (pick < 40) begin
      kind = REQ_SCAN;
    end else if (pick < 68) begin
      kind = REQ_SHOW;
      // mostly displayable numbers, small ones often enough to hit the dash
      case ($urandom_range(0, 4))
        0: v = VALUE_W'($urandom_range(0, 99));
        1: v = VALUE_W'($urandom_range(0, 999));
        2: v = VALUE_W'($urandom_range(0, 99999));
        3: v = VALUE_W'($urandom_range(0, 999999));
        default: ;
      endcase
    end else if (pick < 95) begin
      kind = REQ_SET;
    end else begin
      kind = REQ_NONE;
    end
    acts = !(kind == REQ_NONE || (kind == REQ_SET && p >= POSITIONS_DEF));
    offer_item(kind, v, p, dp);
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned counted;
    int unsigned burst;
    int unsigned gap;
    bit acts;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, blanking and dash rules, glyphs, ignored requests
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SHOW, 20'd5, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SHOW, 20'd1000, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SET, 20'h0000F, 3'd6, 1'b1);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SHOW, 20'd999999, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SHOW, 20'hFFFFF, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SET, 20'hFFFFF, 3'd7, 1'b1);
    offer_item(REQ_SET, 20'hFFFF0, 3'd2, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_NONE, 20'hFFFFF, 3'd7, 1'b1);
    offer_item(REQ_SHOW, 20'd100000, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);
    offer_item(REQ_SHOW, 20'd10000, 3'd0, 1'b0);
    offer_item(REQ_SET, 20'd0, 3'd0, 1'b1);
    offer_item(REQ_SCAN, 20'd0, 3'd0, 1'b0);

    // random bursts, now and then a long one with no gap
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      for (int n = 0; n < burst; n++) begin
        send_random_item(acts);
        counted += acts;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_valid <= 1'b0;

    // drain outstanding scans, then watch for strays
    while (pending_scans != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_scans == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off to back up the input
  initial begin
    int unsigned clock_count;
    int unsigned span;
    int unsigned style;
    bit held;
    held = 1'b0;
    clock_count = 0;
    forever begin
      if (!held && clock_count >= HOLD_START) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        clock_count += HOLD_CYCLES;
      end
      style = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        case (style)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= 1'($urandom_range(0, 1));
          default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
        clock_count++;
      end
    end
  end

  // Watchdog: too long with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
